>>> rtl/core/suk_pkg.sv
// ----------------------------------------------------------------------------
// suk_pkg - shared definitions for the sorted unique key table
// Field widths, operation and status codes, and the command bundle that the
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package suk_pkg;

  localparam int KEY_W         = 32;
  localparam int KIND_W        = 3;
  localparam int POS_W         = 5;
  localparam int STATUS_W      = 3;
  localparam int COUNT_W       = 5;
  localparam int DEFAULT_DEPTH = 16;

  // Operation codes carried by in_kind.
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 3'd4;

  // Command bundle broadcast to all cells.
  typedef struct packed {
    logic eval;       // capture compare flags against the incoming key
    logic shift_ins;  // open a gap at the first greater-or-equal cell
    logic shift_del;  // close the gap at the first greater-or-equal cell
    logic load_tail;  // write the key into the cell just past the last entry
  } cell_cmd_t;

endpackage

>>> rtl/core/suk_cell.sv
// ----------------------------------------------------------------------------
// suk_cell - one storage cell of the key chain
// Holds one key, compares it with the broadcast key, takes part in the
// first-match ripple and shifts toward either neighbor on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module suk_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  suk_pkg::cell_cmd_t                cmd,
  input  logic signed [suk_pkg::KEY_W-1:0]  in_key,
  input  logic        [suk_pkg::POS_W-1:0]  in_position,
  input  logic signed [suk_pkg::KEY_W-1:0]  op_key,
  input  logic        [CNT_W-1:0]           count,
  input  logic signed [suk_pkg::KEY_W-1:0]  prev_key,
  input  logic signed [suk_pkg::KEY_W-1:0]  next_key,
  input  logic                              seen_in,
  output logic                              seen_out,
  output logic                              hit,
  output logic signed [suk_pkg::KEY_W-1:0]  rd_key,
  output logic signed [suk_pkg::KEY_W-1:0]  key_q
);

  localparam int SEL_W = (CNT_W > suk_pkg::POS_W) ? CNT_W : suk_pkg::POS_W;
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [SEL_W-1:0] POS_C = SEL_W'(IDX + 1);

  logic signed [suk_pkg::KEY_W-1:0] key_r;
  logic ge_r, eq_r, sel_r;
  logic occupied, first;

  assign occupied = IDX_C < count;
  // Empty cells count as greater than any key, so an insert that finds no
  // larger key lands at the tail.
  assign first    = ge_r & ~seen_in;
  assign seen_out = seen_in | ge_r;
  assign hit      = first & eq_r;
  assign rd_key   = sel_r ? key_r : '0;
  assign key_q    = key_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ge_r  <= ~occupied | (key_r >= in_key);
      eq_r  <= occupied & (key_r == in_key);
      sel_r <= (SEL_W'(in_position) == POS_C);
    end
    if (cmd.shift_ins) begin
      if (seen_in) begin
        key_r <= prev_key;
      end else if (first) begin
        key_r <= op_key;
      end
    end else if (cmd.shift_del) begin
      if (seen_in | first) begin
        key_r <= next_key;
      end
    end else if (cmd.load_tail && (IDX_C == count)) begin
      key_r <= op_key;
    end
  end

endmodule

>>> rtl/core/sorted_unique_key_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table - ordered table of unique signed keys
// A result is decided in ST_EXEC, which follows the input transfer, and is
// loaded into the output register from there.
// The table works on one item at a time, comparing as it takes the item in
// ST_IDLE and shifting in ST_EXEC. A result held by out_stall keeps the next
// operation waiting in ST_EXEC.
// Reset clears the count and the handshake state; stored keys are not reset
// and are never read before they have been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_unique_key_table #(
  parameter int DEPTH = suk_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [suk_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [suk_pkg::KEY_W-1:0]     in_key,
  input  logic        [suk_pkg::POS_W-1:0]     in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [suk_pkg::STATUS_W-1:0]  out_status,
  output logic signed [suk_pkg::KEY_W-1:0]     out_key_out,
  output logic        [suk_pkg::COUNT_W-1:0]   out_count
);

  // The count runs from zero up to DEPTH inclusive.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > suk_pkg::POS_W) ? CNT_W : suk_pkg::POS_W;
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

  // The controller has two states. In IDLE it takes a transfer and every cell
  // captures its compare flags against the new key. In EXEC the first-match
  // ripple along the chain settles, the operation is decided and, once the
  // output register is free, the cells shift and the result is loaded.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                              state_r;
  logic        [suk_pkg::KIND_W-1:0]   kind_r;
  logic signed [suk_pkg::KEY_W-1:0]    op_key_r;
  logic                                pos_ok_r;
  logic        [CNT_W-1:0]             count_r;
  logic                                out_valid_r;
  logic        [suk_pkg::STATUS_W-1:0] out_status_r;
  logic signed [suk_pkg::KEY_W-1:0]    out_key_r;
  logic        [suk_pkg::COUNT_W-1:0]  out_count_r;

  logic                                accept;
  logic                                done;
  logic                                pos_ok;
  suk_pkg::cell_cmd_t                  cmd;
  logic                                shift_ins, shift_del, load_tail;
  logic        [suk_pkg::STATUS_W-1:0] status_nxt;
  logic signed [suk_pkg::KEY_W-1:0]    key_out_nxt;
  logic        [CNT_W-1:0]             count_nxt;
  logic                                any_hit;
  logic                                full;
  logic signed [suk_pkg::KEY_W-1:0]    rd_merge;

  logic                                seen    [DEPTH+1];
  logic                                hit_v   [DEPTH];
  logic signed [suk_pkg::KEY_W-1:0]    rd_v    [DEPTH];
  logic signed [suk_pkg::KEY_W-1:0]    key_v   [DEPTH];
  logic signed [suk_pkg::KEY_W-1:0]    prev_v  [DEPTH];
  logic signed [suk_pkg::KEY_W-1:0]    next_v  [DEPTH];

  // A new item is taken only while idle; a finished result may still be
  // waiting in the output register at that time.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The operation retires when the output register can take its result.
  assign done     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // A read position is good when it lies between one and the count.
  assign pos_ok = (in_position != '0) &&
                  (CMP_W'(in_position) <= CMP_W'(count_r));

  assign cmd.eval      = accept;
  assign cmd.shift_ins = done & shift_ins;
  assign cmd.shift_del = done & shift_del;
  assign cmd.load_tail = done & load_tail;

  // The chain of cells. The first-match flag ripples from the head, so each
  // cell knows whether a greater-or-equal key sits before it.
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_v[g] = op_key_r;
    end else begin : g_body
      assign prev_v[g] = key_v[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_v[g] = key_v[g];
    end else begin : g_inner
      assign next_v[g] = key_v[g+1];
    end

    suk_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .in_key      (in_key),
      .in_position (in_position),
      .op_key      (op_key_r),
      .count       (count_r),
      .prev_key    (prev_v[g]),
      .next_key    (next_v[g]),
      .seen_in     (seen[g]),
      .seen_out    (seen[g+1]),
      .hit         (hit_v[g]),
      .rd_key      (rd_v[g]),
      .key_q       (key_v[g])
    );
  end

  // At most one cell is the first match and at most one is selected for a
  // read, so plain OR merges give the hit flag and the read data.
  always_comb begin
    any_hit  = 1'b0;
    rd_merge = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit  = any_hit | hit_v[i];
      rd_merge = rd_merge | rd_v[i];
    end
  end

  assign full = (count_r == FULL_C);

  // Operation decode for ST_EXEC. The duplicate check comes before
  // the full check, so a duplicate is reported even on a full table.
  always_comb begin
    status_nxt  = suk_pkg::STAT_OK;
    key_out_nxt = '0;
    count_nxt   = count_r;
    shift_ins   = 1'b0;
    shift_del   = 1'b0;
    load_tail   = 1'b0;
    unique case (kind_r)
      suk_pkg::KIND_INSERT: begin
        if (any_hit) begin
          status_nxt = suk_pkg::STAT_DUP;
        end else if (full) begin
          status_nxt = suk_pkg::STAT_FULL;
        end else begin
          shift_ins = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      suk_pkg::KIND_APPEND: begin
        if (full) begin
          status_nxt = suk_pkg::STAT_FULL;
        end else begin
          load_tail = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      suk_pkg::KIND_DELETE: begin
        if (any_hit) begin
          shift_del = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = suk_pkg::STAT_NOT_FOUND;
        end
      end
      suk_pkg::KIND_READ: begin
        if (pos_ok_r) begin
          key_out_nxt = rd_merge;
        end else begin
          status_nxt = suk_pkg::STAT_BAD_POS;
        end
      end
      suk_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // Unused kinds leave the table as it is and report success.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result takes the output register in the same cycle in which
      // the previous one leaves it.
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_r <= ST_IDLE;
            count_r <= count_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    // Operation and result payload need no reset.
    if (accept) begin
      kind_r   <= in_kind;
      op_key_r <= in_key;
      pos_ok_r <= pos_ok;
    end
    if (done) begin
      out_status_r <= status_nxt;
      out_key_r    <= key_out_nxt;
      out_count_r  <= suk_pkg::COUNT_W'(CMP_W'(count_nxt));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;
  assign out_count   = out_count_r;

endmodule
